FILE: design/mwss_pkg.sv
// package for the masked word sequence scanner
// word and match payload types, command codes, register indexes and defaults
// no dependencies
package mwss_pkg;

    localparam int DEF_PATTERN_DEPTH = 16;

    localparam int CMD_W     = 2;
    localparam int INDEX_W   = 4;
    localparam int DATA_W    = 32;
    localparam int LEN_W     = 5;
    localparam int LIMIT_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MATCHES    = 1'b1;

    localparam logic [LEN_W-1:0]   LEN_RESET   = 5'd1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd16;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [INDEX_W-1:0] entry_index;
        logic [DATA_W-1:0]  entry_mask;
        logic [DATA_W-1:0]  entry_value;
        logic [DATA_W-1:0]  data_word;
    } word_t;

    typedef struct packed {
        logic [DATA_W-1:0]  match_offset;
        logic [LIMIT_W-1:0] match_ordinal;
        logic               limit_reached;
    } match_t;

endpackage

FILE: design/masked_word_sequence_scanner_core.sv
// masked word sequence scanner, top level
// depends on mwss_pkg and mwss_ram
//
// usage:
//   words come in on word_valid / word_stall / word_data. cmd load writes one
//   pattern entry (mask and value), cmd begin clears position, progress,
//   match count and halt, cmd data scans one 32-bit word.
//   a completed sequence gives one word on match_valid / match_stall /
//   match_data: byte offset of the sequence start, the match ordinal and a
//   flag set on the match that reaches max_matches; after that, data words
//   are dropped until the next begin.
//   registers pattern_length and max_matches are set by cfg_we, cfg_index and
//   cfg_data; the user must do so only while the block is idle (unchecked).
// timing:
//   one word per cycle unless a stalled match holds the input register. a word
//   is held in the input register and its match in the result register. the
//   pattern table is a ram read at the next progress value, so the entry for
//   the next word is ready by the time that word is evaluated.
// reset and stall:
//   rst_n clears progress, position, count, halt and both valid flags, and
//   sets pattern_length to 1 and max_matches to 16; pattern entries are not
//   cleared. while match_stall holds a pending match, the input register
//   holds too and word_stall rises once it is full.
module masked_word_sequence_scanner_core
    import mwss_pkg::*;
#(
    parameter int PATTERN_DEPTH = DEF_PATTERN_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 word_valid,
    output logic                 word_stall,
    input  word_t                word_data,
    output logic                 match_valid,
    input  logic                 match_stall,
    output match_t               match_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int CW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
    localparam int EW = 2 * DATA_W;

    // configuration
    logic [LEN_W-1:0]   len_cfg_reg;
    logic [LIMIT_W-1:0] limit_cfg_reg;

    // input register
    logic  s1_valid_reg;
    logic  s1_valid_next;
    word_t s1_reg;
    logic  s1_go;
    logic  accept;

    // scan state
    logic [AW-1:0]      progress_reg;
    logic [AW-1:0]      progress_next;
    logic [DATA_W-1:0]  pos_reg;
    logic [DATA_W-1:0]  pos_next;
    logic [LIMIT_W-1:0] found_reg;
    logic [LIMIT_W-1:0] found_next;
    logic               halted_reg;
    logic               halted_next;

    // result register
    logic   out_valid_reg;
    logic   out_valid_next;
    match_t out_reg;
    match_t out_next;
    logic   produce;

    // pattern table and write bypass
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;
    logic          byp_reg;
    logic [EW-1:0] byp_data_reg;
    logic [EW-1:0] entry;

    logic [CW-1:0]      len_ext;
    logic [CW-1:0]      eff_len;
    logic [CW-1:0]      prog_inc;
    logic [LIMIT_W-1:0] eff_limit;
    logic               hit;

    assign s1_go      = s1_valid_reg && (!out_valid_reg || !match_stall);
    assign word_stall = s1_valid_reg && !s1_go;
    assign accept     = word_valid && !word_stall;

    assign s1_valid_next = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

    assign match_valid = out_valid_reg;
    assign match_data  = out_reg;

    // length clamped to 1..depth, limit of zero acts as one
    always_comb
    begin
        len_ext = CW'(len_cfg_reg);
        priority if (len_ext == '0)
        begin
            eff_len = CW'(1);
        end
        else if (len_ext > CW'(PATTERN_DEPTH))
        begin
            eff_len = CW'(PATTERN_DEPTH);
        end
        else
        begin
            eff_len = len_ext;
        end
        eff_limit = (limit_cfg_reg == '0) ? LIMIT_W'(1) : limit_cfg_reg;
    end

    assign entry    = byp_reg ? byp_data_reg : ram_rdata;
    assign hit      = (s1_reg.data_word & entry[EW-1:DATA_W]) == entry[DATA_W-1:0];
    assign prog_inc = CW'(progress_reg) + CW'(1);

    always_comb
    begin
        progress_next = progress_reg;
        pos_next      = pos_reg;
        found_next    = found_reg;
        halted_next   = halted_reg;
        produce       = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = AW'(s1_reg.entry_index);
        ram_wdata     = {s1_reg.entry_mask, s1_reg.entry_value};
        out_next      = out_reg;

        if (s1_go)
        begin
            unique case (s1_reg.cmd)
                CMD_LOAD:
                begin
                    ram_we = (32'(s1_reg.entry_index) < 32'(PATTERN_DEPTH));
                end
                CMD_BEGIN:
                begin
                    progress_next = '0;
                    pos_next      = '0;
                    found_next    = '0;
                    halted_next   = 1'b0;
                end
                CMD_DATA:
                begin
                    if (!halted_reg)
                    begin
                        pos_next = pos_reg + DATA_W'(4);
                        if (!hit)
                        begin
                            progress_next = '0;
                        end
                        else if (prog_inc < eff_len)
                        begin
                            progress_next = AW'(prog_inc);
                        end
                        else
                        begin
                            progress_next = '0;
                            found_next    = found_reg + LIMIT_W'(1);
                            halted_next   = (found_next >= eff_limit);
                            produce       = 1'b1;
                            out_next.match_offset  = pos_next - (DATA_W'(eff_len) << 2);
                            out_next.match_ordinal = found_next;
                            out_next.limit_reached = halted_next;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid_next = produce ? 1'b1 : (match_stall ? out_valid_reg : 1'b0);

    mwss_ram #(
        .WIDTH (EW),
        .DEPTH (PATTERN_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (progress_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg   <= LEN_RESET;
            limit_cfg_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: len_cfg_reg   <= cfg_data[LEN_W-1:0];
                REG_MAX_MATCHES:    limit_cfg_reg <= cfg_data[LIMIT_W-1:0];
                default:            len_cfg_reg   <= len_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            progress_reg  <= '0;
            pos_reg       <= '0;
            found_reg     <= '0;
            halted_reg    <= 1'b0;
            byp_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            progress_reg  <= progress_next;
            pos_reg       <= pos_next;
            found_reg     <= found_next;
            halted_reg    <= halted_next;
            // ram reads old data on a same-address write, forward the new entry
            byp_reg       <= ram_we && (ram_waddr == progress_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= word_data;
        end
        out_reg      <= out_next;
        byp_data_reg <= ram_wdata;
    end

`ifndef SYNTHESIS
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_reg))
        else $error("input register lost a held word");

    a_limit_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.limit_reached |-> halted_reg)
        else $error("limit match pending without halt");

    a_halt_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg && s1_go && s1_reg.cmd == CMD_DATA |=> $stable(pos_reg) && !$rose(out_valid_reg))
        else $error("halted scan advanced");

    a_ordinal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.match_ordinal != '0)
        else $error("match ordinal is zero");
`endif

endmodule

FILE: design/mwss_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// read returns the old contents when the same address is written in that cycle
// no dependencies
module mwss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sim/testbench.sv
// self-checking testbench for masked_word_sequence_scanner_core
// directed word table, then randomized setting phases; checks against its own scan predictor
// depends on mwss_pkg and the scanner rtl only
`timescale 1ns / 1ps

module testbench;
    import mwss_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int DEPTH      = DEF_PATTERN_DEPTH;
    localparam int DIR_ROWS   = 22;
    localparam int PHASES     = 10;
    localparam int PHASE_WORDS = 175;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_MATCH} row_check_t;

    typedef struct packed {
        logic               set_len;
        logic [LEN_W-1:0]   len;
        logic               set_lim;
        logic [LIMIT_W-1:0] lim;
        word_t              w;
        row_check_t         chk;
        match_t             exp;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 word_valid = 1'b0;
    logic                 word_stall;
    word_t                word_data = '0;
    logic                 match_valid;
    logic                 match_stall = 1'b0;
    match_t               match_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    masked_word_sequence_scanner_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .word_valid  (word_valid),
        .word_stall  (word_stall),
        .word_data   (word_data),
        .match_valid (match_valid),
        .match_stall (match_stall),
        .match_data  (match_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [DATA_W-1:0]  mask_copy [DEPTH];
    logic [DATA_W-1:0]  value_copy [DEPTH];
    logic [LEN_W-1:0]   scan_progress = '0;
    logic [DATA_W-1:0]  scan_position = '0;
    logic [LIMIT_W-1:0] scan_found = '0;
    logic               scan_halted = 1'b0;
    logic [LEN_W-1:0]   reg_length = LEN_RESET;
    logic [LIMIT_W-1:0] reg_limit = LIMIT_RESET;

    match_t   pending_matches [$];
    dir_row_t typed_rows [$];

    // stimulus-side copy of the pattern, used to build matching runs
    logic [DATA_W-1:0] gen_mask [DEPTH];
    logic [DATA_W-1:0] gen_value [DEPTH];
    int gen_len = 1;
    int gen_cap = 0;

    bit word_gaps = 1'b1;
    bit stall_gaps = 1'b1;
    int hold_request = 0;
    int hold_left = 0;

    int error_count = 0;
    int words_taken = 0;
    int matches_checked = 0;
    int halts_seen = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{1'b0, 5'd0, 1'b0, 16'd0, '{CMD_LOAD, 4'd0, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h3C3C_3C3C},
          CHK_NONE, '{32'd0, 16'd0, 1'b0}},
        '{1'b0, 5'd0, 1'b0, 16'd0, '{CMD_DATA, 4'hF, 32'h0, 32'hFFFF_FFFF, 32'hA5A5_A5A5},
          CHK_MATCH, '{32'd0, 16'd1, 1'b0}},
        '{1'b0, 5'd0, 1'b0, 16'd0, '{CMD_DATA, 4'd0, 32'hFFFF_FFFF, 32'h0, 32'h5A5A_5A5A},
          CHK_NONE, '{32'd0, 16'd0, 1'b0}},
        '{1'b0, 5'd0, 1'b0, 16'd0, '{CMD_DATA, 4'd7, 32'h1234_5678, 32'h8765_4321, 32'hA5A5_A5A5},
          CHK_MATCH, '{32'd8, 16'd2, 1'b0}},
        // unknown command carrying a word that would match
        '{1'b0, 5'd0, 1'b0, 16'd0, '{CMD_UNUSED, 4'd0, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'hA5A5_A5A5},
          CHK_NONE, '{32'd0, 16'd0, 1'b0}},
        '{1'b0, 5'd0, 1'b0, 16'd0, '{CMD_LOAD, 4'hF, 32'h0, 32'h0, 32'hFFFF_FFFF},
          CHK_NONE, '{32'd0, 16'd0, 1'b0}},
        '{1'b0, 5'd0, 1'b0, 16'd0, '{CMD_LOAD, 4'd1, 32'h0000_FFFF, 32'h0000_1234, 32'h0},
          CHK_NONE, '{32'd0, 16'd0, 1'b0}},
        '{1'b1, 5'd2, 1'b0, 16'd0, '{CMD_DATA, 4'd3, 32'h0, 32'h0, 32'hA5A5_A5A5},
          CHK_NONE, '{32'd0, 16'd0, 1'b0}},
        '{1'b0, 5'd0, 1'b0, 16'd0, '{CMD_DATA, 4'd2, 32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFF_1234},
          CHK_MODEL, '{32'd0, 16'd0, 1'b0}},
        '{1'b0, 5'd0, 1'b0, 16'd0, '{CMD_DATA, 4'd5, 32'h0, 32'h0, 32'hA5A5_A5A5},
          CHK_MODEL, '{32'd0, 16'd0, 1'b0}},
        // fails entry 1 but would match entry 0: must not be retried
        '{1'b0, 5'd0, 1'b0, 16'd0, '{CMD_DATA, 4'd6, 32'h0, 32'h0, 32'hA5A5_A5A5},
          CHK_MODEL, '{32'd0, 16'd0, 1'b0}},
        '{1'b0, 5'd0, 1'b0, 16'd0, '{CMD_DATA, 4'd1, 32'h0, 32'h0, 32'hFFFF_1234},
          CHK_MODEL, '{32'd0, 16'd0, 1'b0}},
        '{1'b0, 5'd0, 1'b0, 16'd0, '{CMD_DATA, 4'd0, 32'h0, 32'h0, 32'hA5A5_A5A5},
          CHK_MODEL, '{32'd0, 16'd0, 1'b0}},
        // length zero acts as one, and drops below the progress
        '{1'b1, 5'd0, 1'b0, 16'd0, '{CMD_DATA, 4'd0, 32'h0, 32'h0, 32'h0000_1234},
          CHK_MODEL, '{32'd0, 16'd0, 1'b0}},
        // limit zero acts as one, already below the count
        '{1'b0, 5'd0, 1'b1, 16'd0, '{CMD_DATA, 4'd0, 32'h0, 32'h0, 32'hA5A5_A5A5},
          CHK_MODEL, '{32'd0, 16'd0, 1'b0}},
        '{1'b0, 5'd0, 1'b0, 16'd0, '{CMD_DATA, 4'd0, 32'h0, 32'h0, 32'hA5A5_A5A5},
          CHK_NONE, '{32'd0, 16'd0, 1'b0}},
        '{1'b0, 5'd0, 1'b0, 16'd0, '{CMD_BEGIN, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
          CHK_NONE, '{32'd0, 16'd0, 1'b0}},
        '{1'b1, 5'd1, 1'b1, 16'hFFFF, '{CMD_DATA, 4'd0, 32'h0, 32'h0, 32'hFFFF_FFFF},
          CHK_MODEL, '{32'd0, 16'd0, 1'b0}},
        '{1'b0, 5'd0, 1'b0, 16'd0, '{CMD_LOAD, 4'd0, 32'h0, 32'h0, 32'h0},
          CHK_NONE, '{32'd0, 16'd0, 1'b0}},
        '{1'b0, 5'd0, 1'b0, 16'd0, '{CMD_DATA, 4'd0, 32'h0, 32'h0, 32'h0},
          CHK_MATCH, '{32'd4, 16'd1, 1'b0}},
        '{1'b0, 5'd0, 1'b1, 16'd2, '{CMD_DATA, 4'd0, 32'h0, 32'h0, 32'hFFFF_FFFF},
          CHK_MODEL, '{32'd0, 16'd0, 1'b0}},
        // loads still go through while halted
        '{1'b0, 5'd0, 1'b0, 16'd0, '{CMD_LOAD, 4'd0, 32'hFFFF_FFFF, 32'h0, 32'h0},
          CHK_NONE, '{32'd0, 16'd0, 1'b0}}
    };

    int phase_len [PHASES]   = '{16, 31, 1, 4, 2, 8, 0, 5, 3, 12};
    int phase_lim [PHASES]   = '{65535, 3, 65535, 1, 0, 20, 5, 65535, 2, 40};
    bit phase_begin [PHASES] = '{1, 0, 1, 0, 1, 1, 0, 1, 0, 1};

    initial
    begin
        foreach (mask_copy[i])
        begin
            mask_copy[i] = '0;
            value_copy[i] = '0;
            gen_mask[i] = '0;
            gen_value[i] = '0;
        end
    end

    function automatic bit scan_word(input word_t w, output match_t hit);
        logic [LEN_W-1:0]   span;
        logic [LIMIT_W-1:0] cap;
        logic [3:0]         k;
        hit = '0;
        if (w.cmd == CMD_LOAD)
        begin
            mask_copy[w.entry_index] = w.entry_mask;
            value_copy[w.entry_index] = w.entry_value;
            return 1'b0;
        end
        if (w.cmd == CMD_BEGIN)
        begin
            scan_progress = '0;
            scan_position = '0;
            scan_found = '0;
            scan_halted = 1'b0;
            return 1'b0;
        end
        if (w.cmd != CMD_DATA || scan_halted)
            return 1'b0;
        span = (reg_length == 0) ? LEN_W'(1) :
               (reg_length > DEPTH) ? LEN_W'(DEPTH) : reg_length;
        cap = (reg_limit == 0) ? LIMIT_W'(1) : reg_limit;
        scan_position = scan_position + 32'd4;
        k = (scan_progress < DEPTH) ? scan_progress[3:0] : 4'd0;
        if ((w.data_word & mask_copy[k]) != value_copy[k])
        begin
            scan_progress = '0;
            return 1'b0;
        end
        scan_progress = {1'b0, k} + LEN_W'(1);
        if (scan_progress < span)
            return 1'b0;
        scan_progress = '0;
        scan_found = scan_found + LIMIT_W'(1);
        hit.match_offset = scan_position - (32'(span) << 2);
        hit.match_ordinal = scan_found;
        hit.limit_reached = (scan_found >= cap);
        if (hit.limit_reached)
            scan_halted = 1'b1;
        return 1'b1;
    endfunction

    task automatic log_mismatch(input string what);
        error_count++;
        if (error_count <= 10)
            $display("%0t mismatch: %s", $realtime, what);
    endtask

    // predict on accepted words, check accepted matches
    always @(posedge clk)
    begin
        match_t   predicted;
        match_t   want;
        dir_row_t row;
        bit       fired;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_PATTERN_LENGTH)
                    reg_length = cfg_data[LEN_W-1:0];
                else if (cfg_index == REG_MAX_MATCHES)
                    reg_limit = cfg_data[LIMIT_W-1:0];
            end
            if (word_valid && !word_stall)
            begin
                words_taken++;
                fired = scan_word(word_data, predicted);
                if (typed_rows.size() != 0)
                begin
                    row = typed_rows.pop_front();
                    if (row.chk == CHK_MATCH)
                        pending_matches.push_back(row.exp);
                    else if (row.chk == CHK_MODEL && fired)
                        pending_matches.push_back(predicted);
                end
                else if (fired)
                    pending_matches.push_back(predicted);
            end
            if (match_valid && !match_stall)
            begin
                matches_checked++;
                if (match_data.limit_reached === 1'b1)
                    halts_seen++;
                if (pending_matches.size() == 0)
                    log_mismatch($sformatf("unexpected match offset %h ordinal %0d limit %b",
                        match_data.match_offset, match_data.match_ordinal,
                        match_data.limit_reached));
                else
                begin
                    want = pending_matches.pop_front();
                    if (match_data.match_offset !== want.match_offset ||
                        match_data.match_ordinal !== want.match_ordinal ||
                        match_data.limit_reached !== want.limit_reached)
                        log_mismatch($sformatf(
                            "expected offset %h ordinal %0d limit %b, got %h %0d %b",
                            want.match_offset, want.match_ordinal, want.limit_reached,
                            match_data.match_offset, match_data.match_ordinal,
                            match_data.limit_reached));
                end
            end
        end
    end

    // match receiver: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            match_stall <= 1'b1;
            hold_left--;
        end
        else
            match_stall <= rst_n && stall_gaps && ($urandom_range(99) < 35);
    end

    function automatic word_t fresh_word(input logic [CMD_W-1:0] op);
        word_t w;
        w.cmd = op;
        w.entry_index = INDEX_W'($urandom_range(DEPTH - 1));
        w.entry_mask = $urandom;
        w.entry_value = $urandom;
        w.data_word = $urandom;
        return w;
    endfunction

    task automatic send_word(input word_t w);
        while (word_gaps && $urandom_range(99) < 35)
        begin
            word_valid <= 1'b0;
            @(posedge clk);
        end
        if (w.cmd == CMD_LOAD)
        begin
            gen_mask[w.entry_index] = w.entry_mask;
            gen_value[w.entry_index] = w.entry_value;
        end
        word_valid <= 1'b1;
        word_data <= w;
        @(posedge clk);
        while (word_stall)
            @(posedge clk);
    endtask

    // wait until the scanner has nothing in flight
    task automatic settle();
        word_valid <= 1'b0;
        @(posedge clk);
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(input bit do_len, input logic [LEN_W-1:0] len,
                                input bit do_lim, input logic [LIMIT_W-1:0] lim);
        if (do_len)
        begin
            cfg_we <= 1'b1;
            cfg_index <= REG_PATTERN_LENGTH;
            cfg_data <= {{(CFG_W-LEN_W){1'b0}}, len};
            gen_len = (len == 0) ? 1 : (len > DEPTH) ? DEPTH : int'(len);
            @(posedge clk);
        end
        if (do_lim)
        begin
            cfg_we <= 1'b1;
            cfg_index <= REG_MAX_MATCHES;
            cfg_data <= lim;
            gen_cap = (lim == 0) ? 1 : (lim <= 8) ? int'(lim) : 0;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // words that walk the pattern from entry 0; spoil < 0 keeps them all matching
    task automatic send_run(input int upto, input int spoil, inout int sent);
        word_t w;
        for (int k = 0; k < upto; k++)
        begin
            w = fresh_word(CMD_DATA);
            w.data_word = (gen_value[k] & gen_mask[k]) | (w.data_word & ~gen_mask[k]);
            if (k == spoil)
                w.data_word = ~w.data_word;
            send_word(w);
            sent++;
        end
    endtask

    initial
    begin
        word_t w;
        int    sent;
        int    runs;
        int    pick;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].set_len || dir_rows[i].set_lim)
            begin
                settle();
                program_regs(dir_rows[i].set_len, dir_rows[i].len,
                             dir_rows[i].set_lim, dir_rows[i].lim);
            end
            typed_rows.push_back(dir_rows[i]);
            send_word(dir_rows[i].w);
        end

        // fill every entry before the random phases can reach it
        for (int e = 0; e < DEPTH; e++)
        begin
            w = fresh_word(CMD_LOAD);
            w.entry_index = INDEX_W'(e);
            if (e % 5 == 4)
                w.entry_mask = $urandom & $urandom;
            w.entry_value = w.entry_value & w.entry_mask;
            send_word(w);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            word_gaps = !(ph == 4 || ph == 5);
            stall_gaps = word_gaps;
            program_regs(1'b1, LEN_W'(phase_len[ph]), 1'b1, LIMIT_W'(phase_lim[ph]));
            if (ph == 2)
                hold_request = HOLD_CYCLES;
            if (phase_begin[ph])
                send_word(fresh_word(CMD_BEGIN));
            runs = 0;
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                pick = $urandom_range(99);
                if (gen_cap != 0 && runs >= gen_cap)
                begin
                    // scan is likely halted by now, restart it
                    send_word(fresh_word(CMD_BEGIN));
                    runs = 0;
                    sent++;
                end
                else if (pick < 65)
                begin
                    send_run(gen_len,
                             ($urandom_range(9) == 0) ? $urandom_range(gen_len - 1) : -1,
                             sent);
                    runs++;
                end
                else if (pick < 77)
                begin
                    w = fresh_word(CMD_DATA);
                    if (pick < 70)
                        w.data_word = (pick[0]) ? 32'hFFFF_FFFF : 32'h0;
                    send_word(w);
                    sent++;
                end
                else if (pick < 84)
                begin
                    w = fresh_word(CMD_LOAD);
                    if ($urandom_range(19) == 0)
                        w.entry_mask = ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'h0;
                    if ($urandom_range(9) != 0)
                        w.entry_value = w.entry_value & w.entry_mask;
                    send_word(w);
                    sent++;
                end
                else if (pick < 88)
                begin
                    send_word(fresh_word(CMD_BEGIN));
                    runs = 0;
                    sent++;
                end
                else if (pick < 91)
                begin
                    send_word(fresh_word(CMD_UNUSED));
                    sent++;
                end
                else
                    send_run($urandom_range(gen_len - 1), -1, sent);
            end
        end

        word_valid <= 1'b0;
        @(posedge clk);
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("scanned %0d words over %0d setting phases after %0d table rows",
                 words_taken, PHASES, DIR_ROWS);
        $display("compared %0d matches, %0d of them stopped the scan at its limit",
                 matches_checked, halts_seen);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout: scanner stopped making progress");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
